@@ rtl/btpe_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Branch trace packet encoder package
// Shared types, instruction codes and size constants of the encoder.
// ----------------------------------------------------------------------------
package btpe_pkg;

   localparam int MAP_BRANCHES = 31;
   localparam int MAX_PACKET_BYTES_DEF = 26;
   localparam int LEN_W = 8;        // packet length in bits
   localparam int COUNT_W = 5;      // packet length in bytes
   localparam int PKT_MAX_BITS = 205;

   localparam logic [2:0] IT_OTHER     = 3'd0;
   localparam logic [2:0] IT_BR_TAKEN  = 3'd1;
   localparam logic [2:0] IT_BR_NOT    = 3'd2;
   localparam logic [2:0] IT_EXCEPTION = 3'd3;
   localparam logic [2:0] IT_INTERRUPT = 3'd4;
   localparam logic [2:0] IT_JUMP      = 3'd5;
   localparam logic [2:0] IT_CALL      = 3'd6;
   localparam logic [2:0] IT_UNINF     = 3'd7;

   typedef struct packed {
      logic [2:0]  itype;
      logic [63:0] addr;
      logic [2:0]  priv;
      logic [2:0]  retire;
      logic [3:0]  cause;
      logic [63:0] tval;
      logic [63:0] tstamp;
   } rec_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_EMIT
   } back_state_type;

endpackage
`default_nettype wire

@@ rtl/btpe_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Branch trace packet encoder front end
// Keeps the record window and branch map, decides which packet an
// instruction causes and assembles its raw bitstream for the queue.
// ----------------------------------------------------------------------------
module btpe_front #(
   parameter int PKT_BITS = 208
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wr_en,
   input  wire logic                      csr_wr_data,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire btpe_pkg::rec_type         req_rec,
   input  wire btpe_pkg::q_status_type    q_stat,
   output logic                           push,
   output logic [PKT_BITS-1:0]            push_bits,
   output logic [btpe_pkg::LEN_W-1:0]     push_len
);
   import btpe_pkg::*;

   rec_type     s1_ff, s1_in, s2_ff, s2_in;
   logic [30:0] map_ff, map_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        twr_ff, twr_in;
   logic        active_ff, active_in;
   logic        enable_ff, enable_in;

   logic        accept;
   logic        is_br, prev_exc, prev_upd, curr_exc, curr_trap_alone;
   logic        next_exc, next_trap_alone, prev_rep, priv_chg, er_n, full_map;
   logic [30:0] map_upd;
   logic [4:0]  cnt_upd, field;
   logic        do_start, do_trap, do_branch, with_addr, thaddr, ex_sel;
   logic        branch_bit, intr;
   rec_type     ex_rec;
   logic [63:0] diff;
   logic [PKT_MAX_BITS-1:0] v;
   logic [LEN_W-1:0]        vlen;

   assign accept    = req_valid && !q_stat.full;
   assign req_stall = q_stat.full;

   always_comb begin
      is_br   = (s1_ff.itype == IT_BR_TAKEN) || (s1_ff.itype == IT_BR_NOT);
      map_upd = is_br ? {map_ff[29:0], s1_ff.itype == IT_BR_TAKEN} : map_ff;
      cnt_upd = (is_br && cnt_ff < 5'(MAP_BRANCHES)) ? cnt_ff + 5'd1 : cnt_ff;

      prev_exc = (s1_ff.itype == IT_EXCEPTION) || (s1_ff.itype == IT_INTERRUPT);
      prev_upd = (s1_ff.itype == IT_JUMP) || (s1_ff.itype == IT_CALL)
                 || (s1_ff.itype == IT_UNINF);
      curr_exc = (s2_ff.itype == IT_EXCEPTION) || (s2_ff.itype == IT_INTERRUPT);
      curr_trap_alone = curr_exc && (s2_ff.retire == 3'd0);
      next_exc = (req_rec.itype == IT_EXCEPTION) || (req_rec.itype == IT_INTERRUPT);
      next_trap_alone = next_exc && (req_rec.retire == 3'd0);
      prev_rep = prev_exc && twr_ff;
      priv_chg = s2_ff.priv != s1_ff.priv;
      er_n     = (s2_ff.retire != 3'd0) && curr_exc;
      full_map = cnt_upd == 5'(MAP_BRANCHES);

      do_start  = 1'b0;
      do_trap   = 1'b0;
      do_branch = 1'b0;
      with_addr = 1'b1;
      thaddr    = 1'b0;
      ex_sel    = 1'b0;
      active_in = active_ff;
      twr_in    = twr_ff;
      map_in    = map_ff;
      cnt_in    = cnt_ff;

      if (accept) begin
         if (enable_ff) begin
            if (!active_ff) begin
               active_in = 1'b1;
               do_start  = 1'b1;
            end else begin
               twr_in = 1'b0;
               if (prev_exc) begin
                  if (curr_trap_alone || !prev_rep) begin
                     do_trap = 1'b1;
                     thaddr  = 1'b1;
                  end else begin
                     do_start = 1'b1;
                  end
               end else if (prev_upd) begin
                  if (curr_trap_alone) begin
                     do_trap = 1'b1;
                     ex_sel  = 1'b1;
                     twr_in  = 1'b1;
                  end else begin
                     do_branch = 1'b1;
                  end
               end else if (er_n || next_trap_alone || priv_chg) begin
                  do_branch = 1'b1;
               end else if (full_map) begin
                  do_branch = 1'b1;
                  with_addr = 1'b0;
               end
               map_in = map_upd;
               cnt_in = cnt_upd;
            end
         end else if (active_ff) begin
            active_in = 1'b0;
            do_start  = 1'b1;
         end
         if (do_start || do_trap || do_branch) begin
            map_in = '0;
            cnt_in = '0;
         end
      end
   end

   // Packet assembly; the first bit sent sits in bit 0.
   always_comb begin
      ex_rec     = ex_sel ? s2_ff : s1_ff;
      branch_bit = s2_ff.itype != IT_BR_TAKEN;
      intr       = ex_rec.itype == IT_INTERRUPT;
      diff       = s2_ff.addr - s1_ff.addr;
      field      = (cnt_upd >= 5'(MAP_BRANCHES)) ? 5'd0 : cnt_upd;
      v          = '0;
      vlen       = '0;
      if (do_trap) begin
         v = PKT_MAX_BITS'({(intr ? 64'd0 : ex_rec.tval), s2_ff.addr[63:1], thaddr, intr,
                            ex_rec.cause, s2_ff.tstamp, s2_ff.priv, branch_bit,
                            2'b01, 2'b11});
         vlen = 8'd205;
      end else if (do_start) begin
         v = PKT_MAX_BITS'({s2_ff.addr[63:1], s2_ff.tstamp, s2_ff.priv, branch_bit,
                            2'b00, 2'b11});
         vlen = 8'd135;
      end else if (with_addr && cnt_upd == 5'd0) begin
         v    = PKT_MAX_BITS'({2'b00, diff[63:1], 2'b10});
         vlen = 8'd67;
      end else if (field == 5'd0) begin
         v    = PKT_MAX_BITS'({2'b00, map_upd, 5'd0, 2'b01});
         vlen = 8'd40;
      end else if (field <= 5'd3) begin
         v    = PKT_MAX_BITS'({2'b00, diff[63:1], map_upd[2:0], field, 2'b01});
         vlen = 8'd75;
      end else if (field <= 5'd7) begin
         v    = PKT_MAX_BITS'({2'b00, diff[63:1], map_upd[6:0], field, 2'b01});
         vlen = 8'd79;
      end else if (field <= 5'd15) begin
         v    = PKT_MAX_BITS'({2'b00, diff[63:1], map_upd[14:0], field, 2'b01});
         vlen = 8'd87;
      end else begin
         v    = PKT_MAX_BITS'({2'b00, diff[63:1], map_upd, field, 2'b01});
         vlen = 8'd103;
      end
   end

   assign push      = do_start || do_trap || do_branch;
   assign push_bits = PKT_BITS'(v);
   assign push_len  = vlen;

   always_comb begin
      s1_in     = accept ? s2_ff : s1_ff;
      s2_in     = accept ? req_rec : s2_ff;
      enable_in = csr_wr_en ? csr_wr_data : enable_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff     <= '0;
         s2_ff     <= '0;
         map_ff    <= '0;
         cnt_ff    <= '0;
         twr_ff    <= 1'b0;
         active_ff <= 1'b0;
         enable_ff <= 1'b0;
      end else begin
         s1_ff     <= s1_in;
         s2_ff     <= s2_in;
         map_ff    <= map_in;
         cnt_ff    <= cnt_in;
         twr_ff    <= twr_in;
         active_ff <= active_in;
         enable_ff <= enable_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/btpe_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Branch trace packet encoder queue
// Two-entry queue of raw packets between the front and back ends.
// ----------------------------------------------------------------------------
module btpe_queue #(
   parameter int PKT_BITS = 208
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire logic [PKT_BITS-1:0]       push_bits,
   input  wire logic [btpe_pkg::LEN_W-1:0] push_len,
   input  wire logic                      pop,
   output logic [PKT_BITS-1:0]            head_bits,
   output logic [btpe_pkg::LEN_W-1:0]     head_len,
   output btpe_pkg::q_status_type         q_stat
);
   import btpe_pkg::*;

   logic [PKT_BITS-1:0] bits_ff [2];
   logic [LEN_W-1:0]    len_ff [2];
   logic                wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]          cnt_ff, cnt_in;

   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   assign head_bits    = bits_ff[rd_ff];
   assign head_len     = len_ff[rd_ff];
   assign q_stat.full  = cnt_ff == 2'd2;
   assign q_stat.empty = cnt_ff == 2'd0;

   always_ff @(posedge clock) begin
      if (push) begin
         bits_ff[wr_ff] <= push_bits;
         len_ff[wr_ff]  <= push_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/btpe_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Branch trace packet encoder back end
// Finds the cut point of the trailing run one byte per cycle, then sends
// the packet out byte by byte with sign padding.
// ----------------------------------------------------------------------------
module btpe_back #(
   parameter int MAX_PACKET_BYTES = 26
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [MAX_PACKET_BYTES*8-1:0]     head_bits,
   input  wire logic [btpe_pkg::LEN_W-1:0]        head_len,
   input  wire btpe_pkg::q_status_type            q_stat,
   output logic                                   pop,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [7:0]                             rsp_packet_byte,
   output logic [btpe_pkg::COUNT_W-1:0]           rsp_byte_count,
   output logic [btpe_pkg::LEN_W-1:0]             rsp_bit_count,
   output logic                                   rsp_last
);
   import btpe_pkg::*;

   localparam int CHUNK_W = $clog2(MAX_PACKET_BYTES);
   localparam int POS_W   = CHUNK_W + 3;
   localparam int CMP_W   = (POS_W > LEN_W ? POS_W : LEN_W) + 1;

   back_state_type       state_ff, state_in;
   logic [CHUNK_W-1:0]   chunk_ff, chunk_in;
   logic [CHUNK_W-1:0]   byte_ff, byte_in;
   logic [LEN_W-1:0]     cut_ff, cut_in;
   logic [COUNT_W-1:0]   nbytes_ff, nbytes_in;
   logic                 valid_ff, valid_in;
   logic [7:0]           data_ff, data_in;
   logic [COUNT_W-1:0]   bcnt_ff, bcnt_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic                 last_ff, last_in;

   logic [7:0]           chunk_bits, dv, raw;
   logic [POS_W-1:0]     base, pos, epos;
   logic                 prev_bit, hit, fill, load, final_byte;
   logic [2:0]           msb;
   logic [LEN_W-1:0]     cut_dec;

   always_comb begin
      base       = {chunk_ff, 3'b000};
      chunk_bits = head_bits[base +: 8];
      prev_bit   = (chunk_ff != '0) ? head_bits[base - POS_W'(1)] : chunk_bits[0];
      hit        = 1'b0;
      msb        = '0;
      for (int j = 0; j < 8; j++) begin
         pos   = base + POS_W'(j);
         dv[j] = (CMP_W'(pos) < CMP_W'(head_len))
                 && (chunk_bits[j] != ((j == 0) ? prev_bit : chunk_bits[(j + 7) % 8]));
         if (dv[j]) begin
            hit = 1'b1;
            msb = 3'(j);
         end
      end
      cut_dec = LEN_W'(base) + LEN_W'(msb) + LEN_W'(1);
   end

   // Bits at and beyond the cut take the value of the last kept bit.
   always_comb begin
      fill = head_bits[cut_ff - LEN_W'(1)];
      raw  = head_bits[{byte_ff, 3'b000} +: 8];
      for (int j = 0; j < 8; j++) begin
         epos = {byte_ff, 3'b000} + POS_W'(j);
         data_in[j] = (CMP_W'(epos) >= CMP_W'(cut_ff)) ? fill : raw[j];
      end
   end

   always_comb begin
      state_in   = state_ff;
      chunk_in   = chunk_ff;
      byte_in    = byte_ff;
      cut_in     = cut_ff;
      nbytes_in  = nbytes_ff;
      pop        = 1'b0;
      load       = 1'b0;
      final_byte = COUNT_W'(byte_ff) + COUNT_W'(1) == nbytes_ff;
      valid_in   = valid_ff && rsp_stall;
      bcnt_in    = bcnt_ff;
      len_in     = len_ff;
      last_in    = last_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_stat.empty) begin
               chunk_in = CHUNK_W'((head_len - LEN_W'(1)) >> 3);
               state_in = BK_SCAN;
            end
         end
         BK_SCAN: begin
            if (hit || chunk_ff == '0) begin
               cut_in    = hit ? cut_dec : LEN_W'(1);
               nbytes_in = COUNT_W'((cut_in + LEN_W'(7)) >> 3);
               byte_in   = '0;
               state_in  = BK_EMIT;
            end else begin
               chunk_in = chunk_ff - CHUNK_W'(1);
            end
         end
         BK_EMIT: begin
            load = !valid_ff || !rsp_stall;
            if (load) begin
               valid_in = 1'b1;
               bcnt_in  = nbytes_ff;
               len_in   = head_len;
               last_in  = final_byte;
               byte_in  = byte_ff + CHUNK_W'(1);
               if (final_byte) begin
                  pop      = 1'b1;
                  state_in = BK_IDLE;
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   assign rsp_valid       = valid_ff;
   assign rsp_packet_byte = data_ff;
   assign rsp_byte_count  = bcnt_ff;
   assign rsp_bit_count   = len_ff;
   assign rsp_last        = last_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
      chunk_ff  <= chunk_in;
      byte_ff   <= byte_in;
      cut_ff    <= cut_in;
      nbytes_ff <= nbytes_in;
      bcnt_ff   <= bcnt_in;
      len_ff    <= len_in;
      last_ff   <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/branch_trace_packet_encoder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Branch trace packet encoder
// Turns retired-instruction records into byte-wide trace packets.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Payload
//  req_*     in         req_valid/req_stall   one retired-instruction record
//  rsp_*     out        rsp_valid/rsp_stall   one packet byte with its counts
//  csr_*     in         csr_wr_en             trace_enable
//
// An instruction is taken every cycle while the two-entry packet queue has
// room. The back end leaves its idle state to scan the packet byte by byte
// from the top to find its cut point, then sends the packet byte by byte.
// Reset is synchronous and clears the window, map and queue. A stalled
// response holds its byte while the front end keeps working.
module branch_trace_packet_encoder
   import btpe_pkg::*;
#(
   parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_wr_en,
   input  wire logic          csr_wr_data,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [2:0]    req_instr_type,
   input  wire logic [63:0]   req_instr_address,
   input  wire logic [2:0]    req_privilege,
   input  wire logic [2:0]    req_retire_count,
   input  wire logic [3:0]    req_exc_cause,
   input  wire logic [63:0]   req_trap_value,
   input  wire logic [63:0]   req_timestamp,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic [7:0]         rsp_packet_byte,
   output logic [COUNT_W-1:0] rsp_byte_count,
   output logic [LEN_W-1:0]   rsp_bit_count,
   output logic               rsp_last
);

   localparam int PKT_BITS = MAX_PACKET_BYTES * 8;

   rec_type             req_rec;
   q_status_type        q_stat;
   logic                push, pop;
   logic [PKT_BITS-1:0] push_bits, head_bits;
   logic [LEN_W-1:0]    push_len, head_len;

   assign req_rec.itype  = req_instr_type;
   assign req_rec.addr   = req_instr_address;
   assign req_rec.priv   = req_privilege;
   assign req_rec.retire = req_retire_count;
   assign req_rec.cause  = req_exc_cause;
   assign req_rec.tval   = req_trap_value;
   assign req_rec.tstamp = req_timestamp;

   btpe_front #(.PKT_BITS(PKT_BITS)) u_front (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_rec(req_rec),
      .q_stat(q_stat), .push(push), .push_bits(push_bits), .push_len(push_len)
   );

   btpe_queue #(.PKT_BITS(PKT_BITS)) u_queue (
      .clock(clock), .reset(reset),
      .push(push), .push_bits(push_bits), .push_len(push_len),
      .pop(pop), .head_bits(head_bits), .head_len(head_len), .q_stat(q_stat)
   );

   btpe_back #(.MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_back (
      .clock(clock), .reset(reset),
      .head_bits(head_bits), .head_len(head_len), .q_stat(q_stat), .pop(pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_packet_byte(rsp_packet_byte), .rsp_byte_count(rsp_byte_count),
      .rsp_bit_count(rsp_bit_count), .rsp_last(rsp_last)
   );

endmodule
`default_nettype wire

@@ rtl/btpe_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Branch trace packet encoder checker
// Port-level checks of the response stream, bound to the top level.
// ----------------------------------------------------------------------------
module btpe_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_packet_byte,
   input wire logic [4:0] rsp_byte_count,
   input wire logic [7:0] rsp_bit_count,
   input wire logic       rsp_last
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_packet_byte))
      else $error("stalled response changed");

   a_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_byte_count != 5'd0
                    && {rsp_byte_count, 3'b000} <= 8'(rsp_bit_count + 8'd7))
      else $error("byte count does not fit the bit count");

   a_packet_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid
         && $stable(rsp_byte_count) && $stable(rsp_bit_count))
      else $error("packet broken off before its last byte");

endmodule

bind branch_trace_packet_encoder btpe_checker u_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_packet_byte(rsp_packet_byte), .rsp_byte_count(rsp_byte_count),
   .rsp_bit_count(rsp_bit_count), .rsp_last(rsp_last)
);
`default_nettype wire

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// Branch trace packet encoder testbench
// Drives retired-instruction records through directed and random phases,
// predicts every packet byte and checks each response transaction in order.
// ----------------------------------------------------------------------------
module testbench;
   import btpe_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 40;
   localparam int BIT_CAP = 208;

   typedef struct {
      logic [7:0] pbyte;
      logic [4:0] nbytes;
      logic [7:0] nbits;
      logic       last;
   } pkt_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_instr_type = '0;
   logic [63:0] req_instr_address = '0;
   logic [2:0]  req_privilege = '0;
   logic [2:0]  req_retire_count = '0;
   logic [3:0]  req_exc_cause = '0;
   logic [63:0] req_trap_value = '0;
   logic [63:0] req_timestamp = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_packet_byte;
   logic [4:0]  rsp_byte_count;
   logic [7:0]  rsp_bit_count;
   logic        rsp_last;

   branch_trace_packet_encoder dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_instr_type(req_instr_type), .req_instr_address(req_instr_address),
      .req_privilege(req_privilege), .req_retire_count(req_retire_count),
      .req_exc_cause(req_exc_cause), .req_trap_value(req_trap_value),
      .req_timestamp(req_timestamp),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_packet_byte(rsp_packet_byte), .rsp_byte_count(rsp_byte_count),
      .rsp_bit_count(rsp_bit_count), .rsp_last(rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Encoder model state.
   rec_type      win[3];
   int           map_count;
   logic [30:0]  map_bits;
   bit           trap_logged;
   bit           tracing;
   bit           trace_on;
   bit           pkt_bits[BIT_CAP];
   int           pkt_len;
   pkt_byte_type expected_bytes[$];

   int  cycles = 0;
   bit  failed = 0;
   int  idle_pct = 0;
   int  stall_pct = 0;
   int  hold_left = 0;
   logic [63:0] pc = 64'h8000_0000;
   logic [2:0]  cur_priv = 3'd3;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL branch_trace_packet_encoder");
         $finish;
      end
   end

   function automatic void put_field(logic [63:0] v, int w);
      for (int i = 0; i < w; i++)
         if (pkt_len < BIT_CAP) begin
            pkt_bits[pkt_len] = v[i];
            pkt_len++;
         end
   endfunction

   function automatic void finish_packet();
      int cut, padded, nb;
      pkt_byte_type pb;
      if (pkt_len == 0) return;
      cut = pkt_len;
      for (int i = pkt_len - 1; i > 0; i--)
         if (pkt_bits[i] != pkt_bits[i-1]) begin
            cut = i + 1;
            break;
         end
      padded = (cut + 7) / 8 * 8;
      for (int i = cut; i < padded; i++) pkt_bits[i] = pkt_bits[cut-1];
      nb = padded / 8;
      for (int b = 0; b < nb; b++) begin
         for (int i = 0; i < 8; i++) pb.pbyte[i] = pkt_bits[b*8+i];
         pb.nbytes = nb[4:0];
         pb.nbits = pkt_len[7:0];
         pb.last = (b + 1 == nb);
         expected_bytes.insert(expected_bytes.size(), pb);
      end
   endfunction

   function automatic void emit_sync(bit trap, bit thaddr, int ex, bit rep_cond);
      bit intr;
      pkt_len = 0;
      put_field(3, 2);
      put_field(trap ? 1 : 0, 2);
      put_field(win[1].itype == IT_BR_TAKEN ? 0 : 1, 1);
      put_field(win[1].priv, 3);
      put_field(win[1].tstamp, 64);
      if (trap) begin
         intr = (win[ex].itype == IT_INTERRUPT);
         put_field(win[ex].cause, 4);
         put_field(intr, 1);
         put_field(thaddr, 1);
         put_field(win[1].addr >> 1, 63);
         put_field(intr ? 64'd0 : win[ex].tval, 64);
         trap_logged = !thaddr && rep_cond;
      end else
         put_field(win[1].addr >> 1, 63);
      map_count = 0;
      map_bits = '0;
      finish_packet();
   endfunction

   function automatic void emit_branch(bit with_addr);
      logic [63:0] diff;
      int field, len;
      diff = with_addr ? ((win[1].addr - win[0].addr) >> 1) : 64'd0;
      pkt_len = 0;
      if (with_addr && map_count == 0) begin
         put_field(2, 2);
         put_field(diff, 63);
         put_field(0, 2);
      end else begin
         field = (map_count >= MAP_BRANCHES) ? 0 : map_count;
         if (field == 0) len = 31;
         else if (field <= 3) len = 3;
         else if (field <= 7) len = 7;
         else if (field <= 15) len = 15;
         else len = 31;
         put_field(1, 2);
         put_field(field, 5);
         put_field({33'd0, map_bits}, len);
         if (field != 0) put_field(diff, 63);
         put_field(0, 2);
      end
      map_count = 0;
      map_bits = '0;
      finish_packet();
   endfunction

   function automatic bit is_trap(logic [2:0] t);
      return t == IT_EXCEPTION || t == IT_INTERRUPT;
   endfunction

   function automatic bit is_uninferable(logic [2:0] t);
      return t == IT_JUMP || t == IT_CALL || t == IT_UNINF;
   endfunction

   function automatic void encode_step();
      bit prev_exc, prev_upd, curr_trap_alone, next_exc, prev_rep, er_n;
      if (win[0].itype == IT_BR_TAKEN || win[0].itype == IT_BR_NOT) begin
         map_bits = {map_bits[29:0], win[0].itype == IT_BR_TAKEN};
         if (map_count < MAP_BRANCHES) map_count++;
      end
      prev_exc = is_trap(win[0].itype);
      prev_upd = is_uninferable(win[0].itype);
      curr_trap_alone = is_trap(win[1].itype) && win[1].retire == 0;
      next_exc = is_trap(win[2].itype);
      prev_rep = prev_exc && trap_logged;
      trap_logged = 0;
      er_n = win[1].retire != 0 && is_trap(win[1].itype);
      if (prev_exc) begin
         if (curr_trap_alone || !prev_rep) emit_sync(1, 1, 0, prev_upd || next_exc);
         else emit_sync(0, 0, 0, 0);
      end else if (prev_upd) begin
         if (curr_trap_alone) emit_sync(1, 0, 1, 1);
         else emit_branch(1);
      end else if (er_n || (next_exc && win[2].retire == 0) || win[1].priv != win[0].priv)
         emit_branch(1);
      else if (map_count == MAP_BRANCHES)
         emit_branch(0);
   endfunction

   function automatic void predict_record(rec_type r);
      win[0] = win[1];
      win[1] = win[2];
      win[2] = r;
      if (trace_on) begin
         if (!tracing) begin
            tracing = 1;
            emit_sync(0, 0, 0, 0);
         end else
            encode_step();
      end else if (tracing) begin
         tracing = 0;
         emit_sync(0, 0, 0, 0);
      end
   endfunction

   // Sender: one transaction per call, with random idle cycles before it.
   task automatic send_record(rec_type r);
      bit accepted;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_instr_type <= r.itype;
      req_instr_address <= r.addr;
      req_privilege <= r.priv;
      req_retire_count <= r.retire;
      req_exc_cause <= r.cause;
      req_trap_value <= r.tval;
      req_timestamp <= r.tstamp;
      do begin
         @(negedge clock);
         accepted = !req_stall;
         @(posedge clock);
      end while (!accepted);
      predict_record(r);
   endtask

   function automatic rec_type make_record(logic [2:0] t, logic [2:0] ret);
      rec_type r;
      r.itype = t;
      r.addr = pc;
      r.priv = cur_priv;
      r.retire = ret;
      r.cause = 4'($urandom_range(15));
      r.tval = {$urandom, $urandom};
      r.tstamp = {$urandom, $urandom};
      if (t == IT_BR_TAKEN || is_uninferable(t) || is_trap(t))
         pc = {$urandom, $urandom} & ~64'd1;
      else
         pc = pc + 4;
      return r;
   endfunction

   function automatic rec_type random_record();
      int k;
      logic [2:0] t;
      k = $urandom_range(99);
      if (k < 20) t = IT_OTHER;
      else if (k < 45) t = IT_BR_TAKEN;
      else if (k < 70) t = IT_BR_NOT;
      else if (k < 75) t = IT_EXCEPTION;
      else if (k < 79) t = IT_INTERRUPT;
      else if (k < 86) t = IT_JUMP;
      else if (k < 93) t = IT_CALL;
      else t = IT_UNINF;
      if ($urandom_range(19) == 0) cur_priv = 3'($urandom_range(7));
      if ($urandom_range(49) == 0) pc = {$urandom, $urandom};
      return make_record(t, $urandom_range(99) < 85 ? 3'($urandom_range(1, 7)) : 3'd0);
   endfunction

   task automatic drain();
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_trace_enable(bit v);
      req_valid <= 1'b0;
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      trace_on = v;
   endtask

   // Response side: sample at the falling edge, act at the rising edge.
   logic       s_valid = 1'b0, s_stall = 1'b0, s_last;
   logic [7:0] s_byte, s_bits;
   logic [4:0] s_count;

   always @(negedge clock) begin
      s_valid = rsp_valid;
      s_stall = rsp_stall;
      s_byte = rsp_packet_byte;
      s_count = rsp_byte_count;
      s_bits = rsp_bit_count;
      s_last = rsp_last;
   end

   always @(posedge clock) begin
      pkt_byte_type e;
      if (!reset && s_valid === 1'b1 && !s_stall) begin
         if (expected_bytes.size() == 0) begin
            $error("unexpected packet byte %h", s_byte);
            failed = 1;
         end else begin
            e = expected_bytes.pop_front();
            if (s_byte !== e.pbyte) begin
               $error("packet_byte expected %h actual %h", e.pbyte, s_byte);
               failed = 1;
            end
            if (s_count !== e.nbytes) begin
               $error("byte_count expected %0d actual %0d", e.nbytes, s_count);
               failed = 1;
            end
            if (s_bits !== e.nbits) begin
               $error("bit_count expected %0d actual %0d", e.nbits, s_bits);
               failed = 1;
            end
            if (s_last !== e.last) begin
               $error("last expected %0d actual %0d", e.last, s_last);
               failed = 1;
            end
         end
      end
      rsp_stall <= (hold_left > 1) || ($urandom_range(99) < stall_pct);
   end

   // Long receiver hold-off, counted down in its own process.
   always @(posedge clock)
      if (hold_left > 0) hold_left <= hold_left - 1;

   task automatic test_directed();
      rec_type r;
      write_trace_enable(1);
      // Extreme addresses and fields first.
      pc = 64'd0;
      send_record(make_record(IT_OTHER, 3'd1));
      pc = 64'hFFFF_FFFF_FFFF_FFFF;
      cur_priv = 3'd7;
      send_record(make_record(IT_OTHER, 3'd7));
      cur_priv = 3'd0;
      for (int t = 0; t < 8; t++) send_record(make_record(t[2:0], 3'd1));
      // Exception with nothing retired, back to back with an interrupt.
      send_record(make_record(IT_EXCEPTION, 3'd0));
      send_record(make_record(IT_INTERRUPT, 3'd0));
      send_record(make_record(IT_JUMP, 3'd2));
      send_record(make_record(IT_EXCEPTION, 3'd0));
      cur_priv = 3'd1;
      send_record(make_record(IT_BR_NOT, 3'd1));
      send_record(make_record(IT_OTHER, 3'd1));
      write_trace_enable(0);
      // Disabled while tracing gives a closing sync; later items are ignored.
      send_record(make_record(IT_BR_TAKEN, 3'd1));
      send_record(make_record(IT_OTHER, 3'd1));
      r = make_record(IT_EXCEPTION, 3'd0);
      send_record(r);
      write_trace_enable(1);
      send_record(make_record(IT_OTHER, 3'd1));
   endtask

   task automatic test_full_map();
      // Enough branches in a row to fill the map twice over.
      for (int i = 0; i < 70; i++)
         send_record(make_record($urandom_range(1) ? IT_BR_TAKEN : IT_BR_NOT, 3'd1));
      for (int i = 0; i < 3; i++) send_record(make_record(IT_OTHER, 3'd1));
   endtask

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(39) == 0) begin
            write_trace_enable(0);
            repeat ($urandom_range(1, 3)) send_record(random_record());
            write_trace_enable(1);
         end
         send_record(random_record());
      end
   endtask

   task automatic test_random();
      idle_pct = 0;  stall_pct = 0;  random_phase(90);
      idle_pct = 83; stall_pct = 0;  random_phase(80);
      idle_pct = 0;  stall_pct = 83; random_phase(80);
      idle_pct = 31; stall_pct = 31; random_phase(90);
      idle_pct = 0;  stall_pct = 0;
   endtask

   task automatic test_backpressure();
      hold_left = 400;
      for (int i = 0; i < 40; i++) send_record(random_record());
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      map_count = 0;
      map_bits = '0;
      trap_logged = 0;
      tracing = 0;
      trace_on = 0;
      for (int k = 0; k < 3; k++) win[k] = '0;
      @(posedge clock);
      test_directed();
      test_full_map();
      test_random();
      test_backpressure();
      write_trace_enable(0);
      send_record(random_record());
      req_valid <= 1'b0;
      drain();
      if (!failed)
         $display("PASS branch_trace_packet_encoder");
      else
         $display("FAIL branch_trace_packet_encoder");
      $finish;
   end

endmodule
